FILE: rtl/tunnel_fragment_header_parser_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tunnel fragment header parser.
// Each macro expands to one labeled concurrent assertion on clk, disabled
// while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TUNNEL_FRAGMENT_HEADER_PARSER_CORE_ASSERT_SVH
`define TUNNEL_FRAGMENT_HEADER_PARSER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TFHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TFHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tfhp_pkg.sv
// ---------------------------------------------------------------------------
// tfhp_pkg
// Types and constants shared by the tunnel fragment header parser modules.
// ---------------------------------------------------------------------------
package tfhp_pkg;

  localparam int POS_W       = 10;
  localparam int BLOCK_BYTES = 1008;
  localparam int HASH_BYTES  = 32;
  localparam logic [15:0] MAX_FRAG_RESET = 16'd1003;

  // Byte classes.
  localparam logic [3:0] CLS_CHECKSUM  = 4'd0;
  localparam logic [3:0] CLS_PADDING   = 4'd1;
  localparam logic [3:0] CLS_DELIMITER = 4'd2;
  localparam logic [3:0] CLS_FLAG      = 4'd3;
  localparam logic [3:0] CLS_TUNNEL_ID = 4'd4;
  localparam logic [3:0] CLS_HASH      = 4'd5;
  localparam logic [3:0] CLS_MSG_ID    = 4'd6;
  localparam logic [3:0] CLS_SIZE      = 4'd7;
  localparam logic [3:0] CLS_PAYLOAD   = 4'd8;
  localparam logic [3:0] CLS_DISCARD   = 4'd9;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_ZERO   = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  // Delivery types.
  localparam logic [1:0] DT_TUNNEL = 2'd1;
  localparam logic [1:0] DT_ROUTER = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } tfhp_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [3:0]  byte_class;
    logic        block_last;
    logic        desc_valid;
    logic [1:0]  delivery_type;
    logic [31:0] tunnel_id;
    logic [31:0] message_id;
    logic        follow_on;
    logic [5:0]  fragment_number;
    logic        last_fragment;
    logic [15:0] payload_size;
    logic [1:0]  status;
  } tfhp_out_t;

  // Classified byte handed from the parser front to the descriptor back end.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic [3:0]  byte_class;
    logic        block_last;
    logic        desc_valid;
    logic [15:0] size;
    logic [1:0]  status;
  } tfhp_rec_t;

endpackage

FILE: rtl/tfhp_front.sv
// ---------------------------------------------------------------------------
// tfhp_front
// Parser front end: tracks the block position and parse phase, classes each
// byte, checks the fragment size and latches the block status.
// ---------------------------------------------------------------------------
module tfhp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  tfhp_pkg::tfhp_in_t  in_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  output tfhp_pkg::tfhp_rec_t rec
);
  import tfhp_pkg::*;

  typedef enum logic [3:0] {
    PH_CHECKSUM,
    PH_PAD,
    PH_FLAG,
    PH_TID,
    PH_HASH,
    PH_MID,
    PH_SIZE,
    PH_PAYLOAD,
    PH_DISCARD
  } phase_t;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES - 1);

  phase_t           phase_r, phase_nxt, phase_cur;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [5:0]       cnt_r, cnt_nxt, cnt_cur, cnt_inc;
  logic [7:0]       flag_r, flag_nxt, flag_cur;
  logic [15:0]      size_r, size_nxt, size_cur;
  logic [15:0]      rem_r, rem_nxt, rem_cur;
  logic [1:0]       err_r, err_nxt, err_cur;
  logic [15:0]      max_r;
  logic [3:0]       cls;
  logic             desc;
  logic             last;
  logic [7:0]       b;

  always_comb begin
    b = in_item.data_byte;
    // A block start byte sees freshly cleared parser state.
    if (in_item.block_start) begin
      phase_cur = PH_CHECKSUM;
      pos_cur   = '0;
      cnt_cur   = '0;
      flag_cur  = '0;
      size_cur  = '0;
      rem_cur   = '0;
      err_cur   = ST_OK;
    end else begin
      phase_cur = phase_r;
      pos_cur   = pos_r;
      cnt_cur   = cnt_r;
      flag_cur  = flag_r;
      size_cur  = size_r;
      rem_cur   = rem_r;
      err_cur   = err_r;
    end

    cnt_inc   = cnt_cur + 6'd1;
    cls       = CLS_DISCARD;
    desc      = 1'b0;
    phase_nxt = phase_cur;
    cnt_nxt   = cnt_cur;
    flag_nxt  = flag_cur;
    size_nxt  = size_cur;
    rem_nxt   = rem_cur;
    err_nxt   = err_cur;

    case (phase_cur)
      PH_CHECKSUM: begin
        cls = CLS_CHECKSUM;
        if (pos_cur >= POS_W'(3)) begin
          phase_nxt = PH_PAD;
          cnt_nxt   = '0;
        end
      end
      PH_PAD: begin
        if (b != 8'd0) begin
          cls = CLS_PADDING;
        end else begin
          cls       = CLS_DELIMITER;
          phase_nxt = PH_FLAG;
        end
      end
      PH_FLAG: begin
        cls      = CLS_FLAG;
        flag_nxt = b;
        size_nxt = '0;
        cnt_nxt  = '0;
        if (b[7]) begin
          phase_nxt = PH_MID;
        end else if (b[6:5] == DT_TUNNEL) begin
          phase_nxt = PH_TID;
        end else if (b[6:5] == DT_ROUTER) begin
          phase_nxt = PH_HASH;
        end else begin
          phase_nxt = b[3] ? PH_MID : PH_SIZE;
        end
      end
      PH_TID: begin
        cls     = CLS_TUNNEL_ID;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 6'd4) begin
          cnt_nxt   = '0;
          phase_nxt = PH_HASH;
        end
      end
      PH_HASH: begin
        cls     = CLS_HASH;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 6'(HASH_BYTES)) begin
          cnt_nxt   = '0;
          phase_nxt = flag_cur[3] ? PH_MID : PH_SIZE;
        end
      end
      PH_MID: begin
        cls     = CLS_MSG_ID;
        cnt_nxt = cnt_inc;
        if (cnt_inc >= 6'd4) begin
          cnt_nxt   = '0;
          phase_nxt = PH_SIZE;
        end
      end
      PH_SIZE: begin
        cls      = CLS_SIZE;
        size_nxt = {size_cur[7:0], b};
        cnt_nxt  = cnt_inc;
        if (cnt_inc >= 6'd2) begin
          cnt_nxt = '0;
          if (size_nxt > max_r) begin
            err_nxt   = ST_TOO_LONG;
            phase_nxt = PH_DISCARD;
          end else begin
            desc      = 1'b1;
            rem_nxt   = size_nxt;
            phase_nxt = (size_nxt != 16'd0) ? PH_PAYLOAD : PH_FLAG;
          end
        end
      end
      PH_PAYLOAD: begin
        cls     = CLS_PAYLOAD;
        rem_nxt = rem_cur - 16'd1;
        if (rem_nxt == 16'd0) begin
          phase_nxt = PH_FLAG;
        end
      end
      default: begin
        cls       = CLS_DISCARD;
        phase_nxt = PH_DISCARD;
      end
    endcase

    last = (pos_cur >= LAST_POS);
    if (last && err_nxt == ST_OK) begin
      if (phase_nxt == PH_PAD || phase_nxt == PH_CHECKSUM) begin
        err_nxt = ST_NO_ZERO;
      end else if (phase_nxt != PH_FLAG) begin
        err_nxt = ST_TRUNCATED;
      end
    end

    rec.data_byte  = b;
    rec.byte_class = cls;
    rec.block_last = last;
    rec.desc_valid = desc;
    rec.size       = size_nxt;
    rec.status     = err_nxt;

    pos_nxt = pos_cur + POS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CHECKSUM;
      pos_r   <= '0;
      cnt_r   <= '0;
      flag_r  <= '0;
      size_r  <= '0;
      rem_r   <= '0;
      err_r   <= ST_OK;
      max_r   <= MAX_FRAG_RESET;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (accept) begin
        if (last) begin
          // The block ends here; the next byte starts a new block.
          phase_r <= PH_CHECKSUM;
          pos_r   <= '0;
          cnt_r   <= '0;
          flag_r  <= '0;
          size_r  <= '0;
          rem_r   <= '0;
          err_r   <= ST_OK;
        end else begin
          phase_r <= phase_nxt;
          pos_r   <= pos_nxt;
          cnt_r   <= cnt_nxt;
          flag_r  <= flag_nxt;
          size_r  <= size_nxt;
          rem_r   <= rem_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

endmodule

FILE: rtl/tfhp_queue.sv
// ---------------------------------------------------------------------------
// tfhp_queue
// Short first-in first-out queue of classified bytes between front and back.
// ---------------------------------------------------------------------------
module tfhp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tfhp_pkg::tfhp_rec_t wdata,
  output logic                full,
  input  logic                pop,
  output tfhp_pkg::tfhp_rec_t rdata,
  output logic                empty
);
  import tfhp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  tfhp_rec_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/tfhp_back.sv
// ---------------------------------------------------------------------------
// tfhp_back
// Descriptor back end: gathers flag, tunnel id and message id bytes and
// builds the result request in an output register.
// ---------------------------------------------------------------------------
module tfhp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  tfhp_pkg::tfhp_rec_t q_rdata,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output tfhp_pkg::tfhp_out_t out_item
);
  import tfhp_pkg::*;

  logic [7:0]  flag_r;
  logic [31:0] tid_r;
  logic [31:0] mid_r;
  logic        out_valid_r;
  tfhp_out_t   out_r, out_nxt;

  assign q_pop    = !q_empty && (!out_valid_r || pop);
  assign empty    = !out_valid_r;
  assign out_item = out_r;

  // The size byte that completes a descriptor never touches the id shifters,
  // so their current contents are the fragment's fields.
  always_comb begin
    out_nxt                 = '0;
    out_nxt.out_byte        = q_rdata.data_byte;
    out_nxt.byte_class      = q_rdata.byte_class;
    out_nxt.block_last      = q_rdata.block_last;
    out_nxt.desc_valid      = q_rdata.desc_valid;
    out_nxt.status          = q_rdata.status;
    if (q_rdata.desc_valid) begin
      out_nxt.payload_size = q_rdata.size;
      if (flag_r[7]) begin
        out_nxt.message_id      = mid_r;
        out_nxt.follow_on       = 1'b1;
        out_nxt.fragment_number = flag_r[6:1];
        out_nxt.last_fragment   = flag_r[0];
      end else begin
        out_nxt.delivery_type = flag_r[6:5];
        out_nxt.tunnel_id     = (flag_r[6:5] == DT_TUNNEL) ? tid_r : 32'd0;
        out_nxt.message_id    = flag_r[3] ? mid_r : 32'd0;
        out_nxt.last_fragment = !flag_r[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
      case (q_rdata.byte_class)
        CLS_FLAG:      flag_r <= q_rdata.data_byte;
        CLS_TUNNEL_ID: tid_r  <= {tid_r[23:0], q_rdata.data_byte};
        CLS_MSG_ID:    mid_r  <= {mid_r[23:0], q_rdata.data_byte};
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/tunnel_fragment_header_parser_core.sv
// A byte accepted into the queue is popped by the back end into the output register,
// which drives the result ports until the result is popped.
// Throughput: one byte per cycle while the queue is not full; front state updates per byte.
// A stalled result side fills the QUEUE_DEPTH-entry queue plus the output register.
// Reset (rst_n low, synchronous) clears parser state and queues; the size limit
// returns to 1003.
// ---------------------------------------------------------------------------
// tunnel_fragment_header_parser_core
// Tunnel data block fragment header parser: classes each block byte and
// reports a descriptor after the size field of every fragment within the size limit.
// ---------------------------------------------------------------------------
`include "tunnel_fragment_header_parser_core_assert.svh"

module tunnel_fragment_header_parser_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  tfhp_pkg::tfhp_in_t  in_data,
  output logic                empty,
  input  logic                pop,
  output tfhp_pkg::tfhp_out_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  import tfhp_pkg::*;

  tfhp_rec_t front_rec;
  tfhp_rec_t q_rdata;
  logic      q_full, q_empty, q_pop;
  logic      accept;

  assign full   = q_full;
  assign accept = push && !q_full;

  tfhp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rec       (front_rec)
  );

  tfhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_rec),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tfhp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_rdata  (q_rdata),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_data)
  );

  `TFHP_ASSERT_SAME(a_desc_on_size, !empty && out_data.desc_valid,
                    out_data.byte_class == CLS_SIZE,
                    "descriptor on a byte that is not a size byte")
  `TFHP_ASSERT_SAME(a_no_desc_zero, !empty && !out_data.desc_valid,
                    out_data.payload_size == 16'd0 && out_data.tunnel_id == 32'd0 &&
                    out_data.message_id == 32'd0,
                    "descriptor fields set without a descriptor")
  `TFHP_ASSERT_NEXT(a_queue_holds, q_full && !q_pop, q_full,
                    "queue lost an entry while the back end was stalled")

endmodule
